/* rtl/bfpa_pkg.sv */
// Package with the shared constants, types and states of the partition allocator.
`default_nettype none
package bfpa_pkg;
  localparam int MEM_UNITS = 16384;
  localparam int MAX_PARTS = 32;
  localparam int ADDR_W    = 14;
  localparam int SIZE_W    = 15;
  localparam int OWNER_W   = 8;
  localparam int PRN_W     = 8;
  localparam int IDX_W     = $clog2(MAX_PARTS);
  localparam int CNT_W     = $clog2(MAX_PARTS + 1);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // One row of the partition table.
  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [SIZE_W-1:0]  size;
    logic               busy;
    logic [OWNER_W-1:0] owner;
  } part_t;

  // Write request from the sequencer to the table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    part_t            data;
  } part_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SHIFT, ST_WR_LO, ST_WR_HI, ST_MERGE, ST_DONE
  } state_t;
endpackage
`default_nettype wire

/* rtl/bfpa_table.sv */
// Partition table storage: one read port and one write port.
`default_nettype none
module bfpa_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bfpa_pkg::IDX_W-1:0] rd_idx,
  output bfpa_pkg::part_t                 rd_data,
  input  wire bfpa_pkg::part_wr_t         wr
);
  bfpa_pkg::part_t rows_r [bfpa_pkg::MAX_PARTS];

  // Reset leaves one free partition covering the whole memory in row zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i < bfpa_pkg::MAX_PARTS; i++) begin
        rows_r[i] <= '0;
      end
      rows_r[0] <= '{start: '0, size: bfpa_pkg::SIZE_W'(bfpa_pkg::MEM_UNITS),
                     busy: 1'b0, owner: '0};
    end else if (wr.en) begin
      rows_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = rows_r[rd_idx];
endmodule
`default_nettype wire

/* rtl/best_fit_partition_allocator.sv */
// Top level of the best-fit partition allocator: sequencer, shared compare and output register.
// Each request is handled by a small sequencer that walks the partition table one row per
// cycle through a single shared compare and add unit. An allocate makes a best-fit scan over
// the partitions, then, when a split is needed, shifts rows up to open a gap and writes both
// halves; a free makes one release-and-merge pass. The input is not ready while a request is
// in work; a finished word waits in the output register, so the next request may be taken
// before it is collected.
`default_nettype none
module best_fit_partition_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_req_type,
  input  wire logic [bfpa_pkg::OWNER_W-1:0] in_owner_id,
  input  wire logic [bfpa_pkg::SIZE_W-1:0]  in_size_need,
  input  wire logic [bfpa_pkg::PRN_W-1:0]   in_printer_need,
  input  wire logic [bfpa_pkg::PRN_W-1:0]   in_printers_free,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_granted,
  output logic [bfpa_pkg::ADDR_W-1:0]       out_grant_address
);
  localparam int IW = bfpa_pkg::IDX_W;
  localparam int CW = bfpa_pkg::CNT_W;
  localparam int SW = bfpa_pkg::SIZE_W;
  localparam int AW = bfpa_pkg::ADDR_W;

  bfpa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic [SW-1:0] best_size_r, best_size_nxt;
  logic [AW-1:0] best_start_r, best_start_nxt;
  logic          acc_busy_r, acc_busy_nxt;
  logic [SW-1:0] acc_size_r, acc_size_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic [bfpa_pkg::OWNER_W-1:0] owner_r;
  logic [SW-1:0] need_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_granted_r;
  logic [AW-1:0] out_addr_r;

  logic [IW-1:0]      rd_idx;
  bfpa_pkg::part_t    row;
  bfpa_pkg::part_wr_t wr;
  logic               in_acc, load_out;
  logic               fits, cand, last_row, freed, now_busy, fold;
  logic [SW-1:0]      sum;

  bfpa_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_idx),
    .rd_data (row),
    .wr      (wr)
  );

  assign in_ready = (state_r == bfpa_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign rd_idx   = (state_r == bfpa_pkg::ST_SHIFT) ? idx_r - IW'(1) : idx_r;
  assign last_row = ({1'b0, idx_r} == count_r - CW'(1));

  // Shared compare and add unit, used by the scan, the upper-half write and the merge pass.
  assign fits     = !row.busy && (row.size >= need_r);
  assign cand     = fits && (!found_r || (row.size < best_size_r));
  assign freed    = row.busy && (row.owner == owner_r);
  assign now_busy = row.busy && !freed;
  assign fold     = (w_r != '0) && !acc_busy_r && !now_busy;
  assign sum      = fold ? acc_size_r + row.size : {1'b0, best_start_r} + need_r;

  // Sequencer: next state, table writes and result.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    w_nxt          = w_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_size_nxt  = best_size_r;
    best_start_nxt = best_start_r;
    acc_busy_nxt   = acc_busy_r;
    acc_size_nxt   = acc_size_r;
    res_ok_nxt     = res_ok_r;
    res_addr_nxt   = res_addr_r;
    load_out       = 1'b0;
    wr             = '0;
    case (state_r)
      bfpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_nxt      = '0;
          w_nxt        = '0;
          found_nxt    = 1'b0;
          acc_busy_nxt = 1'b0;
          acc_size_nxt = '0;
          res_ok_nxt   = 1'b0;
          res_addr_nxt = '0;
          if (in_req_type == bfpa_pkg::REQ_FREE) begin
            state_nxt = bfpa_pkg::ST_MERGE;
          end else if (in_printer_need > in_printers_free || in_size_need == '0) begin
            state_nxt = bfpa_pkg::ST_DONE;
          end else begin
            state_nxt = bfpa_pkg::ST_SCAN;
          end
        end
      end
      bfpa_pkg::ST_SCAN: begin
        if (cand) begin
          found_nxt      = 1'b1;
          best_nxt       = idx_r;
          best_size_nxt  = row.size;
          best_start_nxt = row.start;
        end
        idx_nxt = idx_r + IW'(1);
        if (last_row) begin
          if (!found_nxt) begin
            state_nxt = bfpa_pkg::ST_DONE;
          end else if (best_size_nxt == need_r) begin
            // Exact fit: mark the row busy in place.
            wr.en         = 1'b1;
            wr.idx        = best_nxt;
            wr.data.start = best_start_nxt;
            wr.data.size  = need_r;
            wr.data.busy  = 1'b1;
            wr.data.owner = owner_r;
            res_ok_nxt    = 1'b1;
            res_addr_nxt  = best_start_nxt;
            state_nxt     = bfpa_pkg::ST_DONE;
          end else if (count_r == CW'(bfpa_pkg::MAX_PARTS)) begin
            state_nxt = bfpa_pkg::ST_DONE;
          end else begin
            idx_nxt   = count_r[IW-1:0];
            state_nxt = bfpa_pkg::ST_SHIFT;
          end
        end
      end
      bfpa_pkg::ST_SHIFT: begin
        // Move rows up by one to open a gap above the chosen row.
        wr.en   = 1'b1;
        wr.idx  = idx_r;
        wr.data = row;
        idx_nxt = idx_r - IW'(1);
        if (rd_idx == best_r) begin
          state_nxt = bfpa_pkg::ST_WR_LO;
        end
      end
      bfpa_pkg::ST_WR_LO: begin
        wr.en         = 1'b1;
        wr.idx        = best_r;
        wr.data.start = best_start_r;
        wr.data.size  = need_r;
        wr.data.busy  = 1'b1;
        wr.data.owner = owner_r;
        state_nxt     = bfpa_pkg::ST_WR_HI;
      end
      bfpa_pkg::ST_WR_HI: begin
        wr.en         = 1'b1;
        wr.idx        = best_r + IW'(1);
        wr.data.start = sum[AW-1:0];
        wr.data.size  = best_size_r - need_r;
        wr.data.busy  = 1'b0;
        wr.data.owner = '0;
        count_nxt     = count_r + CW'(1);
        res_ok_nxt    = 1'b1;
        res_addr_nxt  = best_start_r;
        state_nxt     = bfpa_pkg::ST_DONE;
      end
      bfpa_pkg::ST_MERGE: begin
        // Release the owner's rows and fold free neighbours into one row.
        wr.en = 1'b1;
        if (freed) begin
          res_ok_nxt = 1'b1;
        end
        if (fold) begin
          wr.idx        = IW'(w_r - CW'(1));
          wr.data.start = best_start_r;
          wr.data.size  = sum;
          wr.data.busy  = 1'b0;
          wr.data.owner = '0;
          acc_size_nxt  = sum;
        end else begin
          wr.idx         = w_r[IW-1:0];
          wr.data.start  = row.start;
          wr.data.size   = row.size;
          wr.data.busy   = now_busy;
          wr.data.owner  = now_busy ? row.owner : '0;
          acc_busy_nxt   = now_busy;
          acc_size_nxt   = row.size;
          best_start_nxt = row.start;
          w_nxt          = w_r + CW'(1);
        end
        idx_nxt = idx_r + IW'(1);
        if (last_row) begin
          count_nxt = w_nxt;
          state_nxt = bfpa_pkg::ST_DONE;
        end
      end
      bfpa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = bfpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfpa_pkg::ST_IDLE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    w_r          <= w_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_size_r  <= best_size_nxt;
    best_start_r <= best_start_nxt;
    acc_busy_r   <= acc_busy_nxt;
    acc_size_r   <= acc_size_nxt;
    res_ok_r     <= res_ok_nxt;
    res_addr_r   <= res_addr_nxt;
    if (in_acc) begin
      owner_r    <= in_owner_id;
      need_r     <= in_size_need;
    end
    if (load_out) begin
      out_granted_r <= res_ok_r;
      out_addr_r    <= res_addr_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_grant_address = out_addr_r;
endmodule
`default_nettype wire

/* rtl/bfpa_checker.sv */
// Port checker for the partition allocator, bound to the top level.
`default_nettype none
module bfpa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_granted,
  input wire logic [13:0] out_grant_address
);
  // A pending result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted)
      && $stable(out_grant_address))
    else $error("result word changed while stalled");

  // A refused request reports address zero.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_grant_address == '0)
    else $error("refused request with nonzero address");

  // The block is busy in the cycle after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after an accepted request");

  // A result cannot appear in the cycle right after a request was taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without any work cycles");
endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_granted       (out_granted),
  .out_grant_address (out_grant_address)
);
`default_nettype wire

/* sim/best_fit_partition_allocator_tb.sv */
// Self-checking testbench for the best-fit partition allocator, with its own table predictor.
`timescale 1ns / 1ps
module best_fit_partition_allocator_tb;
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_req_type;
  logic [bfpa_pkg::OWNER_W-1:0] in_owner_id;
  logic [bfpa_pkg::SIZE_W-1:0] in_size_need;
  logic [bfpa_pkg::PRN_W-1:0] in_printer_need;
  logic [bfpa_pkg::PRN_W-1:0] in_printers_free;
  logic out_valid;
  logic out_ready;
  logic out_granted;
  logic [bfpa_pkg::ADDR_W-1:0] out_grant_address;

  best_fit_partition_allocator dut (.*);

  // Expected result word.
  typedef struct packed {
    logic granted;
    logic [bfpa_pkg::ADDR_W-1:0] addr;
  } grant_t;

  grant_t grant_q[$];
  int errors = 0;
  int out_gap_max = 3;

  // Predictor's copy of the partition table.
  logic [bfpa_pkg::ADDR_W-1:0] tbl_start[bfpa_pkg::MAX_PARTS];
  logic [bfpa_pkg::SIZE_W:0] tbl_size[bfpa_pkg::MAX_PARTS];
  logic tbl_busy[bfpa_pkg::MAX_PARTS];
  logic [bfpa_pkg::OWNER_W-1:0] tbl_owner[bfpa_pkg::MAX_PARTS];
  int tbl_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("best_fit_partition_allocator_tb: FAIL");
    $finish;
  end

  function automatic void table_reset();
    for (int i = 0; i < bfpa_pkg::MAX_PARTS; i++) begin
      tbl_start[i] = '0;
      tbl_size[i] = '0;
      tbl_busy[i] = 1'b0;
      tbl_owner[i] = '0;
    end
    tbl_size[0] = (bfpa_pkg::SIZE_W+1)'(bfpa_pkg::MEM_UNITS);
    tbl_count = 1;
  endfunction

  // Releases every row of one owner and, if any matched, joins adjacent free rows.
  function automatic logic release_owner(logic [bfpa_pkg::OWNER_W-1:0] owner);
    logic any;
    int w;
    any = 1'b0;
    w = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i] && tbl_owner[i] == owner) begin
        tbl_busy[i] = 1'b0;
        tbl_owner[i] = '0;
        any = 1'b1;
      end
    end
    if (!any) return 1'b0;
    for (int r = 0; r < tbl_count; r++) begin
      if (w > 0 && !tbl_busy[w-1] && !tbl_busy[r]) begin
        tbl_size[w-1] += tbl_size[r];
      end else begin
        tbl_start[w] = tbl_start[r];
        tbl_size[w] = tbl_size[r];
        tbl_busy[w] = tbl_busy[r];
        tbl_owner[w] = tbl_owner[r];
        w++;
      end
    end
    for (int r = w; r < bfpa_pkg::MAX_PARTS; r++) begin
      tbl_start[r] = '0;
      tbl_size[r] = '0;
      tbl_busy[r] = 1'b0;
      tbl_owner[r] = '0;
    end
    tbl_count = w;
    return 1'b1;
  endfunction

  // Best-fit allocation; returns the grant word.
  function automatic grant_t allocate_best_fit(logic [bfpa_pkg::OWNER_W-1:0] owner,
                                               logic [bfpa_pkg::SIZE_W-1:0] need);
    grant_t g;
    int best;
    g = '0;
    best = -1;
    if (need == 0) return g;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_busy[i] && tbl_size[i] >= need) begin
        if (best < 0 || tbl_size[i] < tbl_size[best]) best = i;
      end
    end
    if (best < 0) return g;
    if (tbl_size[best] != need) begin
      if (tbl_count >= bfpa_pkg::MAX_PARTS) return g;
      for (int i = tbl_count; i > best; i--) begin
        tbl_start[i] = tbl_start[i-1];
        tbl_size[i] = tbl_size[i-1];
        tbl_busy[i] = tbl_busy[i-1];
        tbl_owner[i] = tbl_owner[i-1];
      end
      tbl_count++;
      tbl_size[best] = {1'b0, need};
      tbl_start[best+1] = bfpa_pkg::ADDR_W'(tbl_start[best+1] + need);
      tbl_size[best+1] = tbl_size[best+1] - {1'b0, need};
    end
    tbl_busy[best] = 1'b1;
    tbl_owner[best] = owner;
    g.granted = 1'b1;
    g.addr = tbl_start[best];
    return g;
  endfunction

  // Sends one word, predicting its result on acceptance.
  task automatic send_request(logic rt, logic [bfpa_pkg::OWNER_W-1:0] own,
                              logic [bfpa_pkg::SIZE_W-1:0] need,
                              logic [bfpa_pkg::PRN_W-1:0] pn, logic [bfpa_pkg::PRN_W-1:0] pf,
                              int gap);
    grant_t g;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_owner_id <= own;
    in_size_need <= need;
    in_printer_need <= pn;
    in_printers_free <= pf;
    do @(posedge clk); while (!in_ready);
    if (rt == bfpa_pkg::REQ_FREE) begin
      g.addr = '0;
      g.granted = release_owner(own);
    end else if (pn > pf) begin
      g = '0;
    end else begin
      g = allocate_best_fit(own, need);
    end
    grant_q.push_back(g);
    @(negedge clk);
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Mostly small sizes, sometimes large, and rarely any value up to 32767, zero included.
  function automatic logic [bfpa_pkg::SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return bfpa_pkg::SIZE_W'($urandom_range(1, 64));
    if (r < 85) return bfpa_pkg::SIZE_W'($urandom_range(1, 1024));
    if (r < 97) return bfpa_pkg::SIZE_W'($urandom_range(1, bfpa_pkg::MEM_UNITS));
    return bfpa_pkg::SIZE_W'($urandom_range(0, 32767));
  endfunction

  // Output side: random stalls and checking of each word.
  initial begin
    grant_t exp;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, out_gap_max) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected word granted=%0b addr=%0d", $time, out_granted,
                   out_grant_address);
          errors++;
        end else begin
          exp = grant_q.pop_front();
          if (out_granted !== exp.granted) begin
            $display("%0t: granted expected %0b actual %0b", $time, exp.granted, out_granted);
            errors++;
          end
          if (out_grant_address !== exp.addr) begin
            $display("%0t: grant_address expected %0d actual %0d", $time, exp.addr,
                     out_grant_address);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_request(bfpa_pkg::REQ_ALLOC, 8'd1, 15'd100, 8'd0, 8'd0, 0);
    send_request(bfpa_pkg::REQ_ALLOC, 8'd2, 15'd50, 8'd5, 8'd4, 0);      // printer shortage
    send_request(bfpa_pkg::REQ_ALLOC, 8'd2, 15'd50, 8'd255, 8'd255, 0);
    send_request(bfpa_pkg::REQ_ALLOC, 8'd3, 15'd0, 8'd0, 8'd9, 1);        // zero size
    send_request(bfpa_pkg::REQ_ALLOC, 8'd4, 15'd32767, 8'd0, 8'd1, 0);    // no fit
    send_request(bfpa_pkg::REQ_FREE, 8'd1, 15'd0, 8'd0, 8'd0, 2);
    send_request(bfpa_pkg::REQ_FREE, 8'd1, 15'd0, 8'd0, 8'd0, 0);         // no match
    send_request(bfpa_pkg::REQ_FREE, 8'd0, 15'd0, 8'd0, 8'd0, 0);         // free rows never match
    send_request(bfpa_pkg::REQ_ALLOC, 8'd5, 15'd100, 8'd0, 8'd0, 0);      // exact fit in hole
    send_request(bfpa_pkg::REQ_FREE, 8'd2, 15'd0, 8'd0, 8'd0, 0);
    send_request(bfpa_pkg::REQ_FREE, 8'd5, 15'd0, 8'd0, 8'd0, 0);
    send_request(bfpa_pkg::REQ_ALLOC, 8'd255, 15'd16384, 8'd0, 8'd0, 0);  // whole memory
    send_request(bfpa_pkg::REQ_FREE, 8'd255, 15'd0, 8'd0, 8'd0, 0);
  endtask

  // Fill the table to its limit with tiny grants, then try splits and exact fits.
  task automatic test_full_table();
    for (int i = 0; i < bfpa_pkg::MAX_PARTS + 2; i++)
      send_request(bfpa_pkg::REQ_ALLOC, 8'(10 + i % 4), 15'd1, 8'd0, 8'd0, rand_gap());
    send_request(bfpa_pkg::REQ_FREE, 8'd11, 15'd0, 8'd0, 8'd0, 0);
    send_request(bfpa_pkg::REQ_ALLOC, 8'd20, 15'd1, 8'd0, 8'd0, 0);
    send_request(bfpa_pkg::REQ_ALLOC, 8'd20, 15'd2, 8'd0, 8'd0, 0);
    for (int o = 10; o < 21; o++)
      send_request(bfpa_pkg::REQ_FREE, 8'(o), 15'd0, 8'd0, 8'd0, 0);
  endtask

  // Random requests over a small owner pool so that frees usually match.
  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      logic [bfpa_pkg::OWNER_W-1:0] own;
      logic [bfpa_pkg::PRN_W-1:0] pf;
      own = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      pf = 8'($urandom);
      if (k % 500 == 250) out_gap_max = 40;
      if (k % 500 == 0) out_gap_max = 3;
      if ($urandom_range(0, 99) < 30)
        send_request(bfpa_pkg::REQ_FREE, own, 15'($urandom), 8'($urandom), pf, rand_gap());
      else
        send_request(bfpa_pkg::REQ_ALLOC, own, rand_size(),
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, pf)),
                     pf, rand_gap());
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_req_type = bfpa_pkg::REQ_ALLOC;
    in_owner_id = '0;
    in_size_need = '0;
    in_printer_need = '0;
    in_printers_free = '0;
    rst_n = 1'b0;
    table_reset();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_random(2000);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("best_fit_partition_allocator_tb: PASS");
    end else begin
      $display("best_fit_partition_allocator_tb: FAIL");
    end
    $finish;
  end
endmodule

/* best_fit_partition_allocator.f */
rtl/bfpa_pkg.sv
rtl/bfpa_table.sv
rtl/best_fit_partition_allocator.sv
rtl/bfpa_checker.sv
sim/best_fit_partition_allocator_tb.sv
